[src/brpc_pkg.sv]
// ----------------------------------------------------------------------------
// brpc_pkg
// Shared types and constants for the box region point checker: request
// codes, fixed field widths and the input and result item structs.
// ----------------------------------------------------------------------------
package brpc_pkg;

  // fixed widths of the item fields and the margin register
  localparam int unsigned FieldW  = 32;
  localparam int unsigned MarginW = 31;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_INS_ALLOWED = 2'd0,
    REQ_INS_FORBID  = 2'd1,
    REQ_QUERY       = 2'd2,
    REQ_NOP         = 2'd3
  } req_e;

  // one input item
  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [FieldW-1:0] pt_x;
    logic signed [FieldW-1:0] pt_y;
    logic signed [FieldW-1:0] pt_z;
    logic signed [FieldW-1:0] hi_x;
    logic signed [FieldW-1:0] hi_y;
    logic signed [FieldW-1:0] hi_z;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic point_valid;
    logic status;
  } out_item_t;

endpackage

[src/brpc_ram.sv]
// ----------------------------------------------------------------------------
// brpc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module brpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/brpc_adjust.sv]
// ----------------------------------------------------------------------------
// brpc_adjust
// Moves one box bound by the margin, up or down, and saturates the result
// to the signed stored coordinate range.
// ----------------------------------------------------------------------------
module brpc_adjust #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic signed [31:0]           val_i,
  input  logic [30:0]                  margin_i,
  input  logic                         sub_i,
  output logic signed [COORD_BITS-1:0] bound_o
);
  import brpc_pkg::*;

  localparam int unsigned SW = ((COORD_BITS > FieldW) ? COORD_BITS : FieldW) + 2;

  logic signed [SW-1:0] val_ext;
  logic signed [SW-1:0] mrg_ext;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] cmax;
  logic signed [SW-1:0] cmin;

  // widen, add or subtract
  assign val_ext = {{(SW-FieldW){val_i[FieldW-1]}}, val_i};
  assign mrg_ext = {{(SW-MarginW){1'b0}}, margin_i};
  assign sum     = sub_i ? (val_ext - mrg_ext) : (val_ext + mrg_ext);

  // limits of the stored coordinate
  assign cmax = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  assign cmin = ~cmax;

  // saturate
  always_comb begin
    if (sum > cmax) begin
      bound_o = cmax[COORD_BITS-1:0];
    end else if (sum < cmin) begin
      bound_o = cmin[COORD_BITS-1:0];
    end else begin
      bound_o = sum[COORD_BITS-1:0];
    end
  end

endmodule

[src/brpc_box_cmp.sv]
// ----------------------------------------------------------------------------
// brpc_box_cmp
// Strict containment test of one point against one stored box.
// ----------------------------------------------------------------------------
module brpc_box_cmp #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic signed [31:0]           pt_x_i,
  input  logic signed [31:0]           pt_y_i,
  input  logic signed [31:0]           pt_z_i,
  input  logic signed [COORD_BITS-1:0] lo_x_i,
  input  logic signed [COORD_BITS-1:0] lo_y_i,
  input  logic signed [COORD_BITS-1:0] lo_z_i,
  input  logic signed [COORD_BITS-1:0] hi_x_i,
  input  logic signed [COORD_BITS-1:0] hi_y_i,
  input  logic signed [COORD_BITS-1:0] hi_z_i,
  output logic                         hit_o
);
  import brpc_pkg::*;

  localparam int unsigned SW = ((COORD_BITS > FieldW) ? COORD_BITS : FieldW) + 1;

  logic signed [SW-1:0] px, py, pz;
  logic signed [SW-1:0] lx, ly, lz;
  logic signed [SW-1:0] hx, hy, hz;

  // sign-extend point and box to a common width
  assign px = {{(SW-FieldW){pt_x_i[FieldW-1]}}, pt_x_i};
  assign py = {{(SW-FieldW){pt_y_i[FieldW-1]}}, pt_y_i};
  assign pz = {{(SW-FieldW){pt_z_i[FieldW-1]}}, pt_z_i};
  assign lx = {{(SW-COORD_BITS){lo_x_i[COORD_BITS-1]}}, lo_x_i};
  assign ly = {{(SW-COORD_BITS){lo_y_i[COORD_BITS-1]}}, lo_y_i};
  assign lz = {{(SW-COORD_BITS){lo_z_i[COORD_BITS-1]}}, lo_z_i};
  assign hx = {{(SW-COORD_BITS){hi_x_i[COORD_BITS-1]}}, hi_x_i};
  assign hy = {{(SW-COORD_BITS){hi_y_i[COORD_BITS-1]}}, hi_y_i};
  assign hz = {{(SW-COORD_BITS){hi_z_i[COORD_BITS-1]}}, hi_z_i};

  // strict inside on all three axes, a point on a face is outside
  assign hit_o = (px > lx) && (px < hx) &&
                 (py > ly) && (py < hy) &&
                 (pz > lz) && (pz < hz);

endmodule

[src/box_region_point_checker.sv]
// ----------------------------------------------------------------------------
// box_region_point_checker
// Point test against a table of allowed and forbidden axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request item: insert an
//   allowed box, insert a forbidden box, or query a point. Output channel
//   out_valid_o / out_stall_i returns one result item per request.
//   cfg_we_i / cfg_wdata_i write the margin; write it only while idle.
//   Boxes live in one RAM of MAX_BOXES entries. An insert writes the next
//   free entry with bounds moved by the margin (inward for allowed, outward
//   for forbidden), saturated; into a full table it is dropped with status 1.
//   A query reads the stored boxes one per cycle through the RAM read port
//   and tests each one, so the RAM read port sets the query time.
//   One item is worked on at a time; the next is taken in the cycle after the
//   result is handed to the output register.
//   Reset empties the table (box count zero) and clears the margin. The RAM
//   is not cleared; only entries below the count are ever read.
//   A stalled result sits in the output register; the block may still take
//   and finish one more item, which then waits until that register frees.
// ----------------------------------------------------------------------------
module box_region_point_checker #(
  parameter int unsigned MAX_BOXES  = 16,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [30:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  brpc_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output brpc_pkg::out_item_t  out_item_o
);
  import brpc_pkg::*;

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned EW = 6 * COORD_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INS  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  in_item_t        item_q;
  out_item_t       res_q, res_d;
  out_item_t       out_item_q;
  logic            out_valid_q;
  logic [30:0]     margin_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   idx_q;
  logic            rd_pend_q;
  logic            allowed_q;
  logic            forbid_q;

  logic            in_acc;
  logic            full;
  logic            is_forbid;
  logic            issue;
  logic            ram_we;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;
  logic            hit;
  logic            out_load;

  logic signed [31:0]           adj_src [6];
  logic [5:0]                   adj_sub;
  logic signed [COORD_BITS-1:0] adj_bound [6];

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign full      = (count_q == CW'(MAX_BOXES));
  assign is_forbid = (item_q.req_type == REQ_INS_FORBID);
  assign issue     = (state_q == ST_SCAN) && (idx_q < count_q);
  assign ram_we    = (state_q == ST_INS) && !full;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // margin register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  // bound adjust units, lower bounds first
  assign adj_src[0] = item_q.pt_x;
  assign adj_src[1] = item_q.pt_y;
  assign adj_src[2] = item_q.pt_z;
  assign adj_src[3] = item_q.hi_x;
  assign adj_src[4] = item_q.hi_y;
  assign adj_src[5] = item_q.hi_z;
  assign adj_sub    = {{3{!is_forbid}}, {3{is_forbid}}};

  for (genvar g = 0; g < 6; g++) begin : g_adj
    brpc_adjust #(
      .COORD_BITS(COORD_BITS)
    ) u_adjust (
      .val_i   (adj_src[g]),
      .margin_i(margin_q),
      .sub_i   (adj_sub[g]),
      .bound_o (adj_bound[g])
    );
  end

  assign ram_wdata = {is_forbid, adj_bound[5], adj_bound[4], adj_bound[3],
                      adj_bound[2], adj_bound[1], adj_bound[0]};

  // box table
  brpc_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BOXES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (issue),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // containment test of the entry just read
  brpc_box_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_cmp (
    .pt_x_i(item_q.pt_x),
    .pt_y_i(item_q.pt_y),
    .pt_z_i(item_q.pt_z),
    .lo_x_i(ram_rdata[0*COORD_BITS +: COORD_BITS]),
    .lo_y_i(ram_rdata[1*COORD_BITS +: COORD_BITS]),
    .lo_z_i(ram_rdata[2*COORD_BITS +: COORD_BITS]),
    .hi_x_i(ram_rdata[3*COORD_BITS +: COORD_BITS]),
    .hi_y_i(ram_rdata[4*COORD_BITS +: COORD_BITS]),
    .hi_z_i(ram_rdata[5*COORD_BITS +: COORD_BITS]),
    .hit_o (hit)
  );

  // sequencer next state and result
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          case (in_item_i.req_type)
            REQ_INS_ALLOWED, REQ_INS_FORBID: state_d = ST_INS;
            REQ_QUERY:                       state_d = ST_SCAN;
            default:                         state_d = ST_DONE;
          endcase
        end
      end
      ST_INS: begin
        res_d.status = full;
        state_d      = ST_DONE;
      end
      ST_SCAN: begin
        if (!issue && !rd_pend_q) begin
          res_d.point_valid = allowed_q && !forbid_q;
          state_d           = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      allowed_q <= 1'b0;
      forbid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= issue;
      if (in_acc) begin
        idx_q     <= '0;
        allowed_q <= 1'b0;
        forbid_q  <= 1'b0;
      end else begin
        if (issue) begin
          idx_q <= idx_q + 1'b1;
        end
        // accumulate hits by kind
        if (rd_pend_q && hit) begin
          if (ram_rdata[EW-1]) begin
            forbid_q <= 1'b1;
          end else begin
            allowed_q <= 1'b1;
          end
        end
      end
      if (ram_we) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BOXES))
    else $error("box count beyond table size");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < CW'(MAX_BOXES)))
    else $error("table write while full");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SCAN))
    else $error("read data pending outside a scan");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded without a finished item");

  a_valid_needs_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.point_valid) |-> (count_q != '0))
    else $error("point valid with an empty table");

  a_status_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status) |-> full)
    else $error("drop flagged while table not full");
`endif

endmodule
